@@ src/csa_pkg.sv @@
package csa_pkg;

  localparam logic [2:0] CMD_SUBMIT   = 3'd0;
  localparam logic [2:0] CMD_TICK     = 3'd1;
  localparam logic [2:0] CMD_CLR_SRC  = 3'd2;
  localparam logic [2:0] CMD_CLR_ALL  = 3'd3;
  localparam logic [2:0] CMD_OVERRIDE = 3'd4;

  localparam logic [2:0] CFG_DEFAULT_KIND = 3'd0;
  localparam logic [2:0] CFG_HOLD_WINDOW  = 3'd1;
  localparam logic [2:0] CFG_LOC_PRESENT  = 3'd2;
  localparam logic [2:0] CFG_ATT_PRESENT  = 3'd3;
  localparam logic [2:0] CFG_LOC_WORD     = 3'd4;
  localparam logic [2:0] CFG_ATT_WORD     = 3'd5;

  localparam logic signed [15:0] FAILSAFE_PRIO = -16'sd1;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [2:0]         source_id;
    logic               cmd_kind;
    logic signed [15:0] prio;
    logic [31:0]        stamp;
    logic [31:0]        ttl;
    logic               preemptive;
    logic [31:0]        hold_min;
    logic [63:0]        payload;
    logic [31:0]        now;
  } in_item_t;

  typedef struct packed {
    logic               emit;
    logic               out_kind;
    logic               from_failsafe;
    logic [2:0]         winner_src;
    logic signed [15:0] win_prio;
    logic [63:0]        out_payload;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD_WIN,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic rd_win;
    logic rd_scan;
    logic decide;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic scan_last;
  } dp_status_t;

endpackage

@@ src/csa_ram.sv @@
module csa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/csa_ctrl.sv @@
module csa_ctrl import csa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_status_t status,
  output logic       busy,
  output ctrl_cmd_t  ctrl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_EXEC;
      ST_EXEC:   state_nxt = status.is_tick ? ST_RD_WIN : ST_IDLE;
      ST_RD_WIN: state_nxt = ST_SCAN;
      ST_SCAN:   if (status.scan_last) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state_r != ST_IDLE);
    ctrl         = '0;
    ctrl.latch   = (state_r == ST_IDLE) && start;
    ctrl.exec    = (state_r == ST_EXEC);
    ctrl.rd_win  = (state_r == ST_RD_WIN);
    ctrl.rd_scan = (state_r == ST_SCAN);
    ctrl.decide  = (state_r == ST_DECIDE);
  end

endmodule

@@ src/csa_dp.sv @@
module csa_dp import csa_pkg::*; #(
  parameter int NUM_SOURCES = 8,
  parameter int TIME_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_item,
  input  ctrl_cmd_t   ctrl,
  output dp_status_t  status,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output out_item_t   out_item,
  output logic        out_strobe
);

  localparam int T        = TIME_BITS;
  localparam int CW       = (T > 32) ? T : 32;
  localparam int NSL      = 2 * NUM_SOURCES;
  localparam int SRCW     = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int SW       = SRCW + 1;
  localparam int HOLD_LO  = 64;
  localparam int PRE_LO   = HOLD_LO + T;
  localparam int TTL_LO   = PRE_LO + 1;
  localparam int STAMP_LO = TTL_LO + T;
  localparam int PRIO_LO  = STAMP_LO + T;
  localparam int W        = PRIO_LO + 16;

  in_item_t item_r;

  logic        dkind_r, loc_r, att_r;
  logic [31:0] hlw_r;
  logic [63:0] loc_word_r, att_word_r;

  logic [NSL-1:0]         valid_r;
  logic [NUM_SOURCES-1:0] ovr_set_r;
  logic                   wlive_r;
  logic [SW-1:0]          wslot_r;
  logic [T-1:0]           since_r;

  logic [SW-1:0] cnt_r, ev_idx_r;
  logic          ev_win_r, ev_slot_r;

  logic signed [15:0] w_prio_r, b_prio_r;
  logic [T-1:0]       w_stamp_r, w_hold_r, b_stamp_r;
  logic [63:0]        w_body_r, b_body_r;
  logic               found_r, b_pre_r;
  logic [SW-1:0]      b_idx_r;

  out_item_t out_r, out_nxt;
  logic      strobe_r;

  logic [T-1:0]  now_t, stamp_in_t;
  logic          in_range;
  logic [SW-1:0] in_slot;
  logic [SRCW-1:0] in_src;
  logic          slot_we, ovr_we;
  logic [W-1:0]  slot_wdata, slot_rdata;
  logic [15:0]   ovr_rdata;
  logic [SW-1:0] rd_addr;

  logic signed [15:0] r_prio, r_eff;
  logic [T-1:0]       r_stamp, r_ttl, r_hold, r_diff;
  logic               r_pre, r_live, r_better;
  logic [63:0]        r_body;

  logic [T-1:0] d_since, d_wstamp;
  logic         w_valid, hold_blk, win_blk, pre_ok, do_switch;
  logic         fs_kind, fs_any;

  assign now_t      = T'(item_r.now);
  assign stamp_in_t = (T'(item_r.stamp) != '0) ? T'(item_r.stamp) : now_t;
  assign in_range   = int'(item_r.source_id) < NUM_SOURCES;
  assign in_src     = SRCW'(item_r.source_id);
  assign in_slot    = {in_src, item_r.cmd_kind};
  assign slot_we    = ctrl.exec && (item_r.cmd == CMD_SUBMIT) && in_range;
  assign ovr_we     = ctrl.exec && (item_r.cmd == CMD_OVERRIDE) && in_range;
  assign slot_wdata = {item_r.prio, stamp_in_t, T'(item_r.ttl), item_r.preemptive,
                       T'(item_r.hold_min), item_r.payload};
  assign rd_addr    = ctrl.rd_win ? wslot_r : cnt_r;

  csa_ram #(.WIDTH(W), .DEPTH(NSL), .AW(SW)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (in_slot),
    .wdata (slot_wdata),
    .raddr (rd_addr),
    .rdata (slot_rdata)
  );

  csa_ram #(.WIDTH(16), .DEPTH(NUM_SOURCES), .AW(SRCW)) u_ovr_ram (
    .clk   (clk),
    .we    (ovr_we),
    .waddr (in_src),
    .wdata (item_r.prio),
    .raddr (rd_addr[SW-1:1]),
    .rdata (ovr_rdata)
  );

  always_comb begin
    r_prio   = $signed(slot_rdata[PRIO_LO +: 16]);
    r_stamp  = slot_rdata[STAMP_LO +: T];
    r_ttl    = slot_rdata[TTL_LO +: T];
    r_pre    = slot_rdata[PRE_LO];
    r_hold   = slot_rdata[HOLD_LO +: T];
    r_body   = slot_rdata[63:0];
    r_eff    = ovr_set_r[ev_idx_r[SW-1:1]] ? $signed(ovr_rdata) : r_prio;
    r_diff   = now_t - r_stamp;
    r_live   = valid_r[ev_idx_r] && (r_stamp != '0) && ((r_ttl == '0) || (r_diff <= r_ttl));
    r_better = !found_r || (r_eff > b_prio_r) || ((r_eff == b_prio_r) && (r_stamp > b_stamp_r));
  end

  always_comb begin
    d_since   = now_t - since_r;
    d_wstamp  = now_t - w_stamp_r;
    w_valid   = wlive_r && valid_r[wslot_r];
    hold_blk  = (w_hold_r != '0) && (d_since < w_hold_r);
    win_blk   = (hlw_r != 32'd0) && (CW'(d_wstamp) <= CW'(hlw_r));
    pre_ok    = b_pre_r && ((b_prio_r > w_prio_r) ||
                ((b_prio_r == w_prio_r) && (b_stamp_r > w_stamp_r)));
    do_switch = !w_valid || ((b_idx_r != wslot_r) && !hold_blk && !win_blk && pre_ok);
    fs_any    = loc_r || att_r;
    priority if (!dkind_r && loc_r) fs_kind = 1'b0;
    else if (dkind_r && att_r)      fs_kind = 1'b1;
    else if (loc_r)                 fs_kind = 1'b0;
    else                            fs_kind = 1'b1;
  end

  always_comb begin
    out_nxt = '0;
    if (!found_r) begin
      if (fs_any) begin
        out_nxt.emit          = 1'b1;
        out_nxt.out_kind      = fs_kind;
        out_nxt.from_failsafe = 1'b1;
        out_nxt.win_prio      = FAILSAFE_PRIO;
        out_nxt.out_payload   = fs_kind ? att_word_r : loc_word_r;
      end
    end else begin
      out_nxt.emit = 1'b1;
      if (do_switch) begin
        out_nxt.out_kind    = b_idx_r[0];
        out_nxt.winner_src  = 3'(b_idx_r[SW-1:1]);
        out_nxt.win_prio    = b_prio_r;
        out_nxt.out_payload = b_body_r;
      end else begin
        out_nxt.out_kind    = wslot_r[0];
        out_nxt.winner_src  = 3'(wslot_r[SW-1:1]);
        out_nxt.win_prio    = w_prio_r;
        out_nxt.out_payload = w_body_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      item_r <= in_item;
    end
    ev_idx_r <= rd_addr;
    if (ctrl.rd_win) begin
      cnt_r <= '0;
    end else if (ctrl.rd_scan) begin
      cnt_r <= cnt_r + SW'(1);
    end
    if (ev_win_r) begin
      w_prio_r  <= r_eff;
      w_stamp_r <= r_stamp;
      w_hold_r  <= r_hold;
      w_body_r  <= r_body;
    end
    if (ev_slot_r && r_live && r_better) begin
      b_idx_r   <= ev_idx_r;
      b_prio_r  <= r_eff;
      b_stamp_r <= r_stamp;
      b_pre_r   <= r_pre;
      b_body_r  <= r_body;
    end
    if (ctrl.decide) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dkind_r    <= 1'b0;
      hlw_r      <= 32'd200;
      loc_r      <= 1'b0;
      att_r      <= 1'b0;
      loc_word_r <= '0;
      att_word_r <= '0;
      valid_r    <= '0;
      ovr_set_r  <= '0;
      wlive_r    <= 1'b0;
      wslot_r    <= '0;
      since_r    <= '0;
      ev_win_r   <= 1'b0;
      ev_slot_r  <= 1'b0;
      found_r    <= 1'b0;
      strobe_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_DEFAULT_KIND: dkind_r    <= cfg_data[0];
          CFG_HOLD_WINDOW:  hlw_r      <= cfg_data[31:0];
          CFG_LOC_PRESENT:  loc_r      <= cfg_data[0];
          CFG_ATT_PRESENT:  att_r      <= cfg_data[0];
          CFG_LOC_WORD:     loc_word_r <= cfg_data;
          CFG_ATT_WORD:     att_word_r <= cfg_data;
          default: ;
        endcase
      end
      ev_win_r  <= ctrl.rd_win;
      ev_slot_r <= ctrl.rd_scan;
      strobe_r  <= ctrl.decide;
      if (ctrl.exec) begin
        if (item_r.cmd == CMD_CLR_ALL) begin
          valid_r <= '0;
          wlive_r <= 1'b0;
        end else if (in_range) begin
          if (item_r.cmd == CMD_SUBMIT) begin
            valid_r[in_slot] <= 1'b1;
          end else if (item_r.cmd == CMD_CLR_SRC) begin
            valid_r <= valid_r & ~(NSL'(2'b11) << {in_src, 1'b0});
            if (wslot_r[SW-1:1] == in_src) begin
              wlive_r <= 1'b0;
            end
          end else if (item_r.cmd == CMD_OVERRIDE) begin
            ovr_set_r[in_src] <= 1'b1;
          end
        end
      end
      if (ctrl.rd_win) begin
        found_r <= 1'b0;
      end
      if (ev_slot_r) begin
        if (!r_live) begin
          valid_r[ev_idx_r] <= 1'b0;
        end else begin
          found_r <= 1'b1;
        end
      end
      if (ctrl.decide) begin
        if (!found_r) begin
          wlive_r <= 1'b0;
        end else if (do_switch) begin
          wlive_r <= 1'b1;
          wslot_r <= b_idx_r;
          since_r <= now_t;
        end
      end
    end
  end

  assign status.is_tick   = (item_r.cmd == CMD_TICK);
  assign status.scan_last = (cnt_r == SW'(NSL - 1));
  assign out_item         = out_r;
  assign out_strobe       = strobe_r;

endmodule

@@ src/command_source_arbiter_top.sv @@
// A tick is executed, reads the current winner's slot, then scans all slots at one slot
// per cycle through the slot memory read port before it decides and strobes its result.
// Other commands give no result; one command is in work at a time, so a new command
// is not accepted until the last one is done and busy is low.
// Results appear for one cycle on out_strobe, and the receiver cannot stall them.
// Reset is synchronous and active low; it clears all slots, overrides and the winner.
module command_source_arbiter_top import csa_pkg::*; #(
  parameter int NUM_SOURCES = 8,
  parameter int TIME_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output out_item_t   out_item,
  output logic        out_strobe,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  ctrl_cmd_t  ctrl;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  csa_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .busy   (busy),
    .ctrl   (ctrl)
  );

  csa_dp #(.NUM_SOURCES(NUM_SOURCES), .TIME_BITS(TIME_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .ctrl       (ctrl),
    .status     (status),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_item   (out_item),
    .out_strobe (out_strobe)
  );

endmodule

@@ bench/command_source_arbiter_checker.sv @@
`timescale 1ns / 100ps
module command_source_arbiter_checker import csa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  out_item_t out_item,
  input  logic      out_strobe,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int        fail_count,
  output int        pending
);

  logic        r_kind;
  logic [31:0] r_window;
  logic        r_loc_on, r_att_on;
  logic [63:0] r_loc_word, r_att_word;

  logic               sl_valid [16];
  logic signed [15:0] sl_prio [16];
  logic [31:0]        sl_stamp [16];
  logic [31:0]        sl_ttl [16];
  logic               sl_pre [16];
  logic [31:0]        sl_hold [16];
  logic [63:0]        sl_body [16];
  logic               ov_set [8];
  logic signed [15:0] ov_prio [8];
  logic               win_live;
  logic [3:0]         win_slot;
  logic [31:0]        win_since;

  out_item_t expected_q[$];

  function automatic logic signed [15:0] eff(int s);
    return ov_set[s >> 1] ? ov_prio[s >> 1] : sl_prio[s];
  endfunction

  function automatic logic keep_alive(int s, logic [31:0] now);
    logic [31:0] d;
    d = now - sl_stamp[s];
    if (!sl_valid[s] || sl_stamp[s] == 0) return 1'b0;
    if (sl_ttl[s] == 0) return 1'b1;
    return d <= sl_ttl[s];
  endfunction

  function automatic logic take_over(int c, logic [31:0] now);
    int w;
    logic [31:0] d1, d2;
    w = win_slot;
    d1 = now - win_since;
    d2 = now - sl_stamp[w];
    if (c == w) return 1'b0;
    if (sl_hold[w] != 0 && d1 < sl_hold[w]) return 1'b0;
    if (r_window != 0 && d2 <= r_window) return 1'b0;
    if (eff(c) > eff(w)) return sl_pre[c];
    if (eff(c) == eff(w)) return sl_pre[c] && sl_stamp[c] > sl_stamp[w];
    return 1'b0;
  endfunction

  task automatic arbitrate_tick(logic [31:0] now);
    out_item_t r;
    int best;
    logic found;
    best = 0;
    found = 1'b0;
    r = '0;
    for (int s = 0; s < 16; s++) begin
      if (!keep_alive(s, now)) begin
        sl_valid[s] = 1'b0;
      end else if (!found) begin
        best = s;
        found = 1'b1;
      end else if (eff(s) > eff(best) ||
                   (eff(s) == eff(best) && sl_stamp[s] > sl_stamp[best])) begin
        best = s;
      end
    end
    if (!found) begin
      win_live = 1'b0;
      if ((r_kind == 0 && r_loc_on) || (r_kind == 1 && r_att_on) || r_loc_on || r_att_on) begin
        r.emit = 1'b1;
        if (r_kind == 0 && r_loc_on) r.out_kind = 1'b0;
        else if (r_kind == 1 && r_att_on) r.out_kind = 1'b1;
        else r.out_kind = !r_loc_on;
        r.from_failsafe = 1'b1;
        r.win_prio = FAILSAFE_PRIO;
        r.out_payload = r.out_kind ? r_att_word : r_loc_word;
      end
    end else begin
      if (!sl_valid[win_slot]) win_live = 1'b0;
      if (!win_live || take_over(best, now)) begin
        win_live = 1'b1;
        win_slot = best;
        win_since = now;
      end
      r.emit = 1'b1;
      r.out_kind = win_slot[0];
      r.winner_src = win_slot[3:1];
      r.win_prio = eff(win_slot);
      r.out_payload = sl_body[win_slot];
    end
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic apply_command(in_item_t it);
    int s;
    s = it.source_id * 2 + it.cmd_kind;
    case (it.cmd)
      CMD_TICK: arbitrate_tick(it.now);
      CMD_CLR_ALL: begin
        for (int i = 0; i < 16; i++) sl_valid[i] = 1'b0;
        win_live = 1'b0;
      end
      CMD_SUBMIT: begin
        sl_valid[s] = 1'b1;
        sl_prio[s] = it.prio;
        sl_stamp[s] = it.stamp != 0 ? it.stamp : it.now;
        sl_ttl[s] = it.ttl;
        sl_pre[s] = it.preemptive;
        sl_hold[s] = it.hold_min;
        sl_body[s] = it.payload;
      end
      CMD_CLR_SRC: begin
        sl_valid[s & ~1] = 1'b0;
        sl_valid[s | 1] = 1'b0;
        if (win_live && win_slot[3:1] == it.source_id) win_live = 1'b0;
      end
      CMD_OVERRIDE: begin
        ov_set[it.source_id] = 1'b1;
        ov_prio[it.source_id] = it.prio;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      r_kind <= 1'b0;
      r_window <= 32'd200;
      r_loc_on <= 1'b0;
      r_att_on <= 1'b0;
      r_loc_word <= '0;
      r_att_word <= '0;
      for (int i = 0; i < 16; i++) sl_valid[i] = 1'b0;
      for (int i = 0; i < 8; i++) ov_set[i] = 1'b0;
      win_live = 1'b0;
      win_slot = '0;
      win_since = '0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEFAULT_KIND: r_kind <= cfg_data[0];
          CFG_HOLD_WINDOW:  r_window <= cfg_data[31:0];
          CFG_LOC_PRESENT:  r_loc_on <= cfg_data[0];
          CFG_ATT_PRESENT:  r_att_on <= cfg_data[0];
          CFG_LOC_WORD:     r_loc_word <= cfg_data;
          CFG_ATT_WORD:     r_att_word <= cfg_data;
          default: ;
        endcase
      end
      if (out_strobe) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", out_item.out_payload, '0);
        end else begin
          e = expected_q.pop_front();
          if (out_item.emit !== e.emit)
            report_mismatch("emit", out_item.emit, e.emit);
          if (out_item.out_kind !== e.out_kind)
            report_mismatch("out_kind", out_item.out_kind, e.out_kind);
          if (out_item.from_failsafe !== e.from_failsafe)
            report_mismatch("from_failsafe", out_item.from_failsafe, e.from_failsafe);
          if (out_item.winner_src !== e.winner_src)
            report_mismatch("winner_src", out_item.winner_src, e.winner_src);
          if (out_item.win_prio !== e.win_prio)
            report_mismatch("win_prio", out_item.win_prio, e.win_prio);
          if (out_item.out_payload !== e.out_payload)
            report_mismatch("out_payload", out_item.out_payload, e.out_payload);
        end
      end
      if (start && !busy) apply_command(in_item);
    end
    pending = expected_q.size();
  end

endmodule

@@ bench/command_source_arbiter_top_test.sv @@
`timescale 1ns / 100ps
module command_source_arbiter_top_test;
  import csa_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  out_item_t   out_item;
  logic        out_strobe;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          quiet_cycles = 0;
  logic [31:0] clock_now = 32'd1000;
  int          gap_left = 0;
  logic        quiet_tail = 1'b0;

  localparam int WATCHDOG_LIMIT = 5000;

  always #2 clk = ~clk;

  command_source_arbiter_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_item(out_item), .out_strobe(out_strobe), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  command_source_arbiter_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_item(out_item), .out_strobe(out_strobe), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_command(in_item_t it);
    if (!quiet_tail && gap_left == 0 && $urandom_range(0, 5) == 0)
      gap_left = $urandom_range(1, 12);
    while (gap_left > 0) begin
      @(posedge clk);
      gap_left--;
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    while (pending != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t rand_item(bit well_formed);
    in_item_t it;
    it = '0;
    it.cmd = well_formed ? (($urandom_range(0, 9) < 5) ? CMD_TICK :
             ($urandom_range(0, 5) == 0 ? CMD_OVERRIDE :
             ($urandom_range(0, 9) == 0 ? CMD_CLR_SRC : CMD_SUBMIT)))
             : 3'($urandom_range(0, 7));
    it.source_id = 3'($urandom);
    it.cmd_kind = 1'($urandom);
    it.prio = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 6)) - 16'sd3;
    case ($urandom_range(0, 3))
      0: it.stamp = 32'd0;
      1: it.stamp = $urandom;
      default: it.stamp = clock_now - 32'($urandom_range(0, 300));
    endcase
    case ($urandom_range(0, 3))
      0: it.ttl = 32'd0;
      1: it.ttl = $urandom;
      default: it.ttl = 32'($urandom_range(1, 400));
    endcase
    it.preemptive = 1'($urandom);
    case ($urandom_range(0, 3))
      0: it.hold_min = 32'd0;
      1: it.hold_min = $urandom;
      default: it.hold_min = 32'($urandom_range(1, 200));
    endcase
    it.payload = {$urandom, $urandom};
    if (it.cmd == CMD_TICK) clock_now = clock_now + 32'($urandom_range(0, 120));
    it.now = $urandom_range(0, 30) == 0 ? 32'($urandom) : clock_now;
    return it;
  endfunction

  function automatic in_item_t make_item(logic [2:0] c, logic [2:0] src, logic k,
                                         logic signed [15:0] p, logic [31:0] st,
                                         logic [31:0] tl, logic pe, logic [31:0] mh,
                                         logic [63:0] pl, logic [31:0] nw);
    in_item_t it;
    it = '{c, src, k, p, st, tl, pe, mh, pl, nw};
    return it;
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_command(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 32'd5));
    write_reg(CFG_LOC_PRESENT, 64'd1);
    write_reg(CFG_LOC_WORD, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_ATT_WORD, 64'hA5A5_0000_FFFF_1234);
    send_command(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 32'd6));
    write_reg(CFG_DEFAULT_KIND, 64'd1);
    send_command(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 32'd7));
    write_reg(CFG_ATT_PRESENT, 64'd1);
    send_command(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 32'd8));
    send_command(make_item(CMD_SUBMIT, 7, 1, 16'sh7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                           32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd9));
    send_command(make_item(CMD_SUBMIT, 0, 0, -16'sh8000, 0, 0, 0, 0, 64'd1, 32'd0));
    send_command(make_item(CMD_SUBMIT, 3, 0, 16'sd5, 0, 32'd10, 1, 0, 64'd3, 32'd100));
    send_command(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 32'd100));
    send_command(make_item(CMD_SUBMIT, 4, 1, 16'sd5, 32'd150, 0, 1, 0, 64'd4, 32'd150));
    send_command(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 32'd400));
    send_command(make_item(CMD_OVERRIDE, 0, 0, 16'sd100, 0, 0, 0, 0, 0, 0));
    send_command(make_item(CMD_SUBMIT, 0, 1, 16'sd0, 32'd390, 0, 1, 0, 64'd7, 32'd400));
    send_command(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 32'd401));
    send_command(make_item(3'd5, 2, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_item(3'd7, 2, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_item(CMD_CLR_SRC, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_command(make_item(CMD_CLR_ALL, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 32'd402));
    write_reg(CFG_HOLD_WINDOW, 64'd0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: begin
          write_reg(CFG_HOLD_WINDOW, 64'hFFFF_FFFF);
          write_reg(CFG_DEFAULT_KIND, 64'd0);
          write_reg(CFG_LOC_PRESENT, 64'd0);
        end
        2: begin
          write_reg(CFG_HOLD_WINDOW, 64'd50);
          write_reg(CFG_ATT_PRESENT, 64'd0);
          write_reg(CFG_LOC_WORD, 64'd0);
        end
        3: begin
          write_reg(CFG_HOLD_WINDOW, 64'd0);
          write_reg(CFG_LOC_PRESENT, 64'd1);
          write_reg(CFG_ATT_PRESENT, 64'd1);
          write_reg(CFG_DEFAULT_KIND, 64'd1);
          write_reg(CFG_ATT_WORD, 64'd0);
        end
        default: ;
      endcase
      for (int n = 0; n < 95; n++) begin
        if (phase == 3 && n > 60) quiet_tail = 1'b1;
        send_command(rand_item($urandom_range(0, 9) != 0));
      end
    end

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
